FILE: rtl/alfl_pkg.sv
package alfl_pkg;

   // operation codes on req_func
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // result codes on rsp_status
   localparam logic [1:0] ST_INSERTED  = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_REMOVED   = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam int KEY_W = 32;

   // contents of one cell: an occupied flag and its key
   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
   } ent_type;

   // walk token passed from cell to cell during a remove
   typedef struct packed {
      logic search;  // still looking for a matching key
      logic shift;   // match found upstream, close the gap
   } tok_type;

   // end-of-walk report from a cell
   typedef struct packed {
      logic removed;
      logic missing;
   } done_type;

endpackage

FILE: rtl/alfl_cell.sv
module alfl_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load_left,
   input  alfl_pkg::ent_type                 left,
   input  alfl_pkg::ent_type                 right,
   input  alfl_pkg::tok_type                 tok_in,
   input  logic signed [alfl_pkg::KEY_W-1:0] search_key,
   output alfl_pkg::ent_type                 ent,
   output alfl_pkg::tok_type                 tok_out,
   output alfl_pkg::done_type                done
);

   logic                              valid_ff, valid_in;
   logic signed [alfl_pkg::KEY_W-1:0] key_ff, key_in;
   alfl_pkg::tok_type                 tok_ff;
   logic                              match;
   logic                              hit;
   logic                              pull;

   assign ent.valid = valid_ff;
   assign ent.key   = key_ff;

   // compare against the searched key and decide what the token does next
   always_comb begin
      match           = valid_ff & (key_ff == search_key);
      hit             = tok_ff.search & match;
      pull            = hit | tok_ff.shift;
      tok_out.search  = tok_ff.search & valid_ff & ~match;
      tok_out.shift   = pull & right.valid;
      done.missing    = tok_ff.search & ~valid_ff;
      done.removed    = pull & ~right.valid;
   end

   // shift in from the head side on insert, from the tail side to close a gap
   always_comb begin
      if (load_left) begin
         valid_in = left.valid;
         key_in   = left.key;
      end else if (pull) begin
         valid_in = right.valid;
         key_in   = right.key;
      end else begin
         valid_in = valid_ff;
         key_in   = key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

FILE: rtl/array_linked_list_with_free_list.sv
// Pool of CAPACITY keys kept as a list, most recent insert at the head.
// The list is held in a row of cells in list order, cell 0 being the head,
// so the used cells always form a prefix of the row. On an insert every
// cell takes its head-side neighbor and the new key enters cell 0; the
// result appears the cycle after start and busy never rises. A full pool
// refuses the insert with no change. A remove sends a token down the row
// one cell per cycle; at the first equal key the cell drops its entry and
// the token closes the gap by pulling each following cell up one place.
// A remove ends when the gap has closed at the last used cell or, if the
// key is absent, when the token meets an empty cell or leaves the tail.
// busy is high while a remove walks. The result is shown for one cycle on
// rsp_valid and cannot be held off.
module array_linked_list_with_free_list #(
   parameter int CAPACITY = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_func,
   input  logic signed [alfl_pkg::KEY_W-1:0] req_key,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   logic                              state_ff, state_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [1:0]                        rsp_status_ff, rsp_status_in;
   logic signed [alfl_pkg::KEY_W-1:0] key_ff, key_in;

   alfl_pkg::ent_type  ent_v     [CAPACITY];
   alfl_pkg::tok_type  tok_v     [CAPACITY];
   alfl_pkg::done_type done_v    [CAPACITY];
   logic [CAPACITY-1:0] removed_v;
   logic [CAPACITY-1:0] missing_v;

   logic               accept;
   logic               full;
   logic               insert_go;
   alfl_pkg::tok_type  inject;
   alfl_pkg::ent_type  new_ent;
   logic               walk_removed;
   logic               walk_missing;

   assign busy       = (state_ff == S_WALK);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   assign accept    = start & ~busy;
   assign full      = ent_v[CAPACITY-1].valid;
   assign insert_go = accept & (req_func == alfl_pkg::FUNC_INSERT) & ~full;

   assign inject.search = accept & (req_func == alfl_pkg::FUNC_REMOVE);
   assign inject.shift  = 1'b0;
   assign new_ent.valid = 1'b1;
   assign new_ent.key   = req_key;

   // row of cells, head at index 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      alfl_pkg::ent_type left_ent;
      alfl_pkg::ent_type right_ent;
      alfl_pkg::tok_type tok_in;

      if (i == 0) begin : g_head
         assign left_ent = new_ent;
         assign tok_in   = inject;
      end else begin : g_mid
         assign left_ent = ent_v[i-1];
         assign tok_in   = tok_v[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_ent = '0;
      end else begin : g_body
         assign right_ent = ent_v[i+1];
      end

      alfl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .load_left  (insert_go),
         .left       (left_ent),
         .right      (right_ent),
         .tok_in     (tok_in),
         .search_key (key_ff),
         .ent        (ent_v[i]),
         .tok_out    (tok_v[i]),
         .done       (done_v[i])
      );

      assign removed_v[i] = done_v[i].removed;
      assign missing_v[i] = done_v[i].missing;
   end

   // a search token leaving the tail cell found nothing
   assign walk_removed = |removed_v;
   assign walk_missing = (|missing_v) | tok_v[CAPACITY-1].search;

   // control: idle takes requests, walk waits for the token to finish
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      key_in        = key_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_func == alfl_pkg::FUNC_INSERT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = full ? alfl_pkg::ST_FULL : alfl_pkg::ST_INSERTED;
               end else begin
                  key_in   = req_key;
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            if (walk_removed) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = alfl_pkg::ST_REMOVED;
               state_in      = S_IDLE;
            end else if (walk_missing) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = alfl_pkg::ST_NOT_FOUND;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      key_ff        <= key_in;
   end

endmodule

FILE: rtl/alfl_checker.sv
module alfl_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_func,
   input logic       rsp_valid,
   input logic [1:0] rsp_status
);

   // an accepted insert answers in the next cycle without going busy
   a_insert_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == alfl_pkg::FUNC_INSERT |=>
         rsp_valid && !busy &&
         (rsp_status == alfl_pkg::ST_INSERTED || rsp_status == alfl_pkg::ST_FULL))
      else $error("insert did not answer in one cycle");

   // an accepted remove starts a walk
   a_remove_walks: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_func == alfl_pkg::FUNC_REMOVE |=> busy && !rsp_valid)
      else $error("remove did not start a walk");

   // the end of a walk shows a remove result
   a_walk_answers: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid &&
         (rsp_status == alfl_pkg::ST_REMOVED || rsp_status == alfl_pkg::ST_NOT_FOUND))
      else $error("walk ended without a remove result");

   // no result while a walk is still running
   a_no_result_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result shown during a walk");

endmodule

bind array_linked_list_with_free_list alfl_checker u_alfl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_func   (req_func),
   .rsp_valid  (rsp_valid),
   .rsp_status (rsp_status)
);

FILE: verif/array_linked_list_with_free_list_tb.sv
module array_linked_list_with_free_list_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CAP         = 8;
   localparam logic [3:0]  LINK_NIL    = 4'(CAP);
   localparam int          PHASE_OPS   = 282;
   localparam int          TAIL_CYCLES = CAP + 4;
   localparam int          CYCLE_LIMIT = 400000;

   // one pending request, or a barrier that holds off until all results are in
   typedef struct {
      bit                              barrier;
      logic                            func;
      logic [alfl_pkg::KEY_W-1:0]      key;
      int unsigned                     gap_pct;
   } op_item_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       req_func = alfl_pkg::FUNC_INSERT;
   logic [alfl_pkg::KEY_W-1:0] req_key = '0;
   logic                       busy;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;

   op_item_type op_backlog[$];
   logic [1:0]  status_due[$];
   int          err_count = 0;
   int          checked_count = 0;
   int          cycle_count = 0;

   // shadow of the entry pool: keys, forward/back links, list and free heads
   logic [alfl_pkg::KEY_W-1:0] slot_key[CAP];
   logic [3:0]                 fwd_link[CAP];
   logic [3:0]                 back_link[CAP];
   logic [3:0]                 used_head;
   logic [3:0]                 spare_head;

   array_linked_list_with_free_list #(.CAPACITY(CAP)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_func   (req_func),
      .req_key    (req_key),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // apply one operation to the shadow pool and return the status it gives
   function automatic logic [1:0] apply_to_pool(input logic func,
                                                input logic [alfl_pkg::KEY_W-1:0] key);
      logic [3:0] slot;
      logic [3:0] cur;
      logic [3:0] after;
      logic [3:0] prior;
      int         steps;
      if (func == alfl_pkg::FUNC_INSERT) begin
         slot = spare_head;
         if (slot >= LINK_NIL) return alfl_pkg::ST_FULL;
         spare_head = fwd_link[slot];
         if (used_head < LINK_NIL) back_link[used_head] = slot;
         slot_key[slot]  = key;
         back_link[slot] = LINK_NIL;
         fwd_link[slot]  = used_head;
         used_head       = slot;
         return alfl_pkg::ST_INSERTED;
      end
      // walk from the head, unlink the first equal key, push it on the free list
      cur = used_head;
      for (steps = 0; steps < CAP && cur < LINK_NIL; steps++) begin
         if (slot_key[cur] == key) begin
            after = fwd_link[cur];
            prior = back_link[cur];
            if (prior < LINK_NIL) fwd_link[prior] = after;
            else used_head = after;
            if (after < LINK_NIL) back_link[after] = prior;
            fwd_link[cur] = spare_head;
            spare_head    = cur;
            return alfl_pkg::ST_REMOVED;
         end
         cur = fwd_link[cur];
      end
      return alfl_pkg::ST_NOT_FOUND;
   endfunction

   task automatic log_mismatch(input string what);
      err_count++;
      if (err_count <= 100) $display("mismatch: %s", what);
   endtask

   task automatic queue_op(input logic func, input logic [alfl_pkg::KEY_W-1:0] key,
                           input int unsigned pct);
      op_item_type it;
      it.barrier = 1'b0;
      it.func    = func;
      it.key     = key;
      it.gap_pct = pct;
      op_backlog.push_back(it);
   endtask

   task automatic queue_barrier();
      op_item_type it;
      it.barrier = 1'b1;
      it.func    = alfl_pkg::FUNC_INSERT;
      it.key     = '0;
      it.gap_pct = 0;
      op_backlog.push_back(it);
   endtask

   // driver: predict on each transfer, then present the next request or idle
   always @(posedge clock) begin
      op_item_type nxt;
      logic        go;
      go = 1'b0;
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (start) status_due.push_back(apply_to_pool(req_func, req_key));
         if (op_backlog.size() > 0 && op_backlog[0].barrier) begin
            if (status_due.size() == 0) void'(op_backlog.pop_front());
         end else if (op_backlog.size() > 0 &&
                      $urandom_range(99) >= op_backlog[0].gap_pct) begin
            nxt = op_backlog.pop_front();
            req_func <= nxt.func;
            req_key  <= nxt.key;
            go = 1'b1;
         end
         start <= go;
      end
   end

   // monitor: compare each result with the oldest expected status
   always @(posedge clock) begin
      logic [1:0] want;
      if (!reset && rsp_valid) begin
         if (status_due.size() == 0) begin
            log_mismatch($sformatf("unexpected result, status %0d", rsp_status));
         end else begin
            want = status_due.pop_front();
            if (rsp_status !== want)
               log_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      checked_count, rsp_status, want));
            checked_count++;
         end
      end
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [alfl_pkg::KEY_W-1:0] pool[12];
      int unsigned                phase_gap[4];
      int unsigned                ins_pct;
      logic [alfl_pkg::KEY_W-1:0] k;
      logic                       fn;

      // reset state of the shadow pool
      for (int i = 0; i < CAP; i++) begin
         slot_key[i]  = '0;
         back_link[i] = LINK_NIL;
         fwd_link[i]  = (i + 1 < CAP) ? 4'(i + 1) : LINK_NIL;
      end
      used_head  = LINK_NIL;
      spare_head = 4'd0;

      // directed: empty remove, extremes, fill to full, duplicates, unlink at
      // head, middle and tail, free entry reuse, drain to empty
      queue_op(alfl_pkg::FUNC_REMOVE, 32'd5,          0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h8000_0000,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h7FFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h0000_0000,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'hFFFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h5555_5555,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'hAAAA_AAAA,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'hFFFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h0000_0001,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h0000_0002,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'hFFFF_FFFE,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'hFFFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'hFFFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'hFFFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'h8000_0000,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'h0000_0001,  0);
      queue_op(alfl_pkg::FUNC_INSERT, 32'h0000_0003,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'h0000_0000,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'h0000_0003,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'h7FFF_FFFF,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'h5555_5555,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'hAAAA_AAAA,  0);
      queue_op(alfl_pkg::FUNC_REMOVE, 32'hAAAA_AAAA,  0);
      queue_barrier();

      // random phases: no idling, heavy sender gaps, light gaps, no idling
      phase_gap[0] = 0;
      phase_gap[1] = 73;
      phase_gap[2] = 7;
      phase_gap[3] = 0;
      for (int ph = 0; ph < 4; ph++) begin
         pool[0] = 32'h8000_0000;
         pool[1] = 32'h7FFF_FFFF;
         pool[2] = 32'h0000_0000;
         pool[3] = 32'hFFFF_FFFF;
         for (int i = 4; i < 12; i++) pool[i] = $urandom;
         ins_pct = 50;
         for (int n = 0; n < PHASE_OPS; n++) begin
            // swing the insert bias so the pool fills up and drains
            if (n % 47 == 0) ins_pct = 25 * $urandom_range(1, 3);
            fn = ($urandom_range(99) < ins_pct) ? alfl_pkg::FUNC_INSERT
                                                : alfl_pkg::FUNC_REMOVE;
            k  = ($urandom_range(99) < 75) ? pool[$urandom_range(11)] : $urandom;
            queue_op(fn, k, phase_gap[ph]);
         end
         queue_barrier();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // hold until every request is transferred and every result is in
      while (op_backlog.size() != 0 || start || status_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: array_linked_list_with_free_list.f
rtl/alfl_pkg.sv
rtl/alfl_cell.sv
rtl/array_linked_list_with_free_list.sv
rtl/alfl_checker.sv
verif/array_linked_list_with_free_list_tb.sv
